// ===== hdl/elq_pkg.sv =====
package elq_pkg;

    localparam int FLOOR_W    = 6;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    // requests for floors above this are refused
    localparam logic [FLOOR_W-1:0] MAX_FLOOR = 6'd63;

    localparam logic [FLOOR_W-1:0] RESET_FLOOR = 6'd1;

    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;
    localparam logic DIR_UP       = 1'b1;
    localparam logic DIR_DOWN     = 1'b0;

    // flag bits summed per recount cycle
    localparam int CHUNK_W = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CNT_LD,
        ST_CNT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_item;
        logic insert;
        logic pop;
        logic cnt_load;
        logic cnt_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic mode;
    } t_status;

endpackage

// ===== hdl/elevator_look_request_queues.sv =====
// Two-car elevator request queues with LOOK ordering. A slave transaction with
// tuser = 0 inserts tdata's floor into the up (direction 1) or down (direction 0)
// car's queue in sorted position; tuser = 1 pops the head of each non-empty queue
// and moves that car there. Every transaction yields one master transaction with
// the accept flag, the served flags and both car floors. Each queue is a row of
// QUEUE_DEPTH register cells that insert with a parallel compare and shift. A
// request passes through the execute and done states after acceptance; an advance
// also passes through the recount load and recount states, since after each pop
// the size of the first section of each queue is recounted 8 cells per cycle. A new transaction
// is taken while the previous result still waits in the output register.
module elevator_look_request_queues #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [5:0] floor, [6] direction, [7] zero
    input  logic [elq_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // [0] mode
    input  logic                           i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [0] request_accepted, [1] up_served, [7:2] up_floor, [8] down_served,
    // [14:9] down_floor, [15] zero
    output logic [elq_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import elq_pkg::*;

    t_cmd    cmd;
    t_status status;

    elq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s_valid(i_s_axis_tvalid),
        .o_s_ready(o_s_axis_tready),
        .i_m_ready(i_m_axis_tready),
        .o_m_valid(o_m_axis_tvalid),
        .i_status (status),
        .o_cmd    (cmd)
    );

    elq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_data  (i_s_axis_tdata),
        .i_user  (i_s_axis_tuser),
        .o_status(status),
        .o_data  (o_m_axis_tdata)
    );

endmodule

// ===== hdl/elq_queue.sv =====
module elq_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_ascending,
    input  logic                         i_insert,
    input  logic [elq_pkg::FLOOR_W-1:0]  i_floor,
    input  logic                         i_pop,
    input  logic                         i_cnt_load,
    input  logic                         i_cnt_step,
    output logic                         o_full,
    output logic                         o_nonempty,
    output logic [elq_pkg::FLOOR_W-1:0]  o_pos
);
    import elq_pkg::*;

    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int NCH = (QUEUE_DEPTH + CHUNK_W - 1) / CHUNK_W;
    localparam int FW  = NCH * CHUNK_W;
    localparam int LV  = $clog2(QUEUE_DEPTH);
    localparam int PW  = $clog2(CHUNK_W + 1);

    logic [FLOOR_W-1:0] r_q [QUEUE_DEPTH];
    logic [FLOOR_W-1:0] n_q [QUEUE_DEPTH];
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_g;      // entries in the first section
    logic [FLOOR_W-1:0] r_pos;
    logic [FW-1:0]      r_flag;

    logic                   in_first;
    logic [QUEUE_DEPTH-1:0] valid;
    logic [QUEUE_DEPTH-1:0] below_hi;
    logic [QUEUE_DEPTH-1:0] hit;
    logic [QUEUE_DEPTH-1:0] keep;
    logic [QUEUE_DEPTH-1:0] sect_a;
    logic [QUEUE_DEPTH-1:0] pre [LV+1];
    logic [PW-1:0]          popcnt;

    assign in_first = i_ascending ? (i_floor > r_pos) : (i_floor < r_pos);

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            logic lt_g;
            logic cmp;
            lt_g        = CW'(i) < r_g;
            valid[i]    = CW'(i) < r_count;
            cmp         = i_ascending ? (r_q[i] >= i_floor) : (r_q[i] <= i_floor);
            below_hi[i] = in_first ? lt_g : valid[i];
            hit[i]      = (in_first ? lt_g : (!lt_g && valid[i])) && cmp;
            sect_a[i]   = valid[i] &&
                          (i_ascending ? (r_q[i] > r_pos) : (r_q[i] < r_pos));
        end
    end

    // prefix OR of the hit vector, log-depth
    assign pre[0] = hit;
    for (genvar k = 0; k < LV; k++) begin : g_lvl
        for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_bit
            if (i >= (1 << k)) begin : g_or
                assign pre[k+1][i] = pre[k][i] | pre[k][i-(1<<k)];
            end else begin : g_pass
                assign pre[k+1][i] = pre[k][i];
            end
        end
    end

    // cells ahead of the insertion point hold their value
    assign keep = below_hi & ~pre[LV];

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (keep[i]) begin
                n_q[i] = r_q[i];
            end else if (i == 0) begin
                n_q[i] = i_floor;
            end else if (keep[i-1]) begin
                n_q[i] = i_floor;
            end else begin
                n_q[i] = r_q[i-1];
            end
        end
    end

    always_comb begin
        popcnt = '0;
        for (int i = 0; i < CHUNK_W; i++) begin
            popcnt = popcnt + PW'(r_flag[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_insert) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_q[i] <= n_q[i];
            end
        end else if (i_pop && (r_count != '0)) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                r_q[i] <= r_q[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cnt_load) begin
            r_flag <= FW'(sect_a);
        end else if (i_cnt_step) begin
            r_flag <= r_flag >> CHUNK_W;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_g     <= '0;
            r_pos   <= RESET_FLOOR;
        end else begin
            if (i_insert) begin
                r_count <= r_count + CW'(1);
                if (in_first) begin
                    r_g <= r_g + CW'(1);
                end
            end else if (i_pop && (r_count != '0)) begin
                r_count <= r_count - CW'(1);
                r_pos   <= r_q[0];
            end
            if (i_cnt_load) begin
                r_g <= '0;
            end else if (i_cnt_step) begin
                r_g <= r_g + CW'(popcnt);
            end
        end
    end

    assign o_full     = (r_count == CW'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_pos      = r_pos;

endmodule

// ===== hdl/elq_datapath.sv =====
module elq_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  elq_pkg::t_cmd                  i_cmd,
    input  logic [elq_pkg::IN_DATA_W-1:0]  i_data,
    input  logic                           i_user,
    output elq_pkg::t_status               o_status,
    output logic [elq_pkg::OUT_DATA_W-1:0] o_data
);
    import elq_pkg::*;

    logic               r_mode;
    logic [FLOOR_W-1:0] r_floor;
    logic               r_dir;
    logic               r_acc;
    logic               r_up_srv;
    logic               r_dn_srv;
    logic [OUT_DATA_W-1:0] r_out;

    logic               up_full;
    logic               dn_full;
    logic               up_nonempty;
    logic               dn_nonempty;
    logic [FLOOR_W-1:0] up_pos;
    logic [FLOOR_W-1:0] dn_pos;
    logic               ok;
    logic               up_ins;
    logic               dn_ins;

    assign ok = (r_floor <= MAX_FLOOR) && ((r_dir == DIR_UP) ? !up_full : !dn_full);
    assign up_ins = i_cmd.insert && ok && (r_dir == DIR_UP);
    assign dn_ins = i_cmd.insert && ok && (r_dir == DIR_DOWN);

    elq_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_up (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ascending(1'b1),
        .i_insert   (up_ins),
        .i_floor    (r_floor),
        .i_pop      (i_cmd.pop),
        .i_cnt_load (i_cmd.cnt_load),
        .i_cnt_step (i_cmd.cnt_step),
        .o_full     (up_full),
        .o_nonempty (up_nonempty),
        .o_pos      (up_pos)
    );

    elq_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dn (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ascending(1'b0),
        .i_insert   (dn_ins),
        .i_floor    (r_floor),
        .i_pop      (i_cmd.pop),
        .i_cnt_load (i_cmd.cnt_load),
        .i_cnt_step (i_cmd.cnt_step),
        .o_full     (dn_full),
        .o_nonempty (dn_nonempty),
        .o_pos      (dn_pos)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode  <= i_user;
            r_floor <= i_data[FLOOR_W-1:0];
            r_dir   <= i_data[FLOOR_W];
        end
        if (i_cmd.insert) begin
            r_acc    <= ok;
            r_up_srv <= 1'b0;
            r_dn_srv <= 1'b0;
        end else if (i_cmd.pop) begin
            r_acc    <= 1'b0;
            r_up_srv <= up_nonempty;
            r_dn_srv <= dn_nonempty;
        end
        if (i_cmd.load_out) begin
            r_out <= {1'b0, dn_pos, r_dn_srv, up_pos, r_up_srv, r_acc};
        end
    end

    assign o_status.mode = r_mode;
    assign o_data        = r_out;

endmodule

// ===== hdl/elq_ctrl.sv =====
module elq_ctrl #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    output logic             o_s_ready,
    input  logic             i_m_ready,
    output logic             o_m_valid,
    input  elq_pkg::t_status i_status,
    output elq_pkg::t_cmd    o_cmd
);
    import elq_pkg::*;

    localparam int NCH = (QUEUE_DEPTH + CHUNK_W - 1) / CHUNK_W;
    localparam int KW  = (NCH > 1) ? $clog2(NCH) : 1;

    t_state        r_state;
    t_state        n_state;
    logic [KW-1:0] r_chunk;
    logic [KW-1:0] n_chunk;
    logic          r_m_valid;
    logic          n_m_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_chunk   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_chunk   <= n_chunk;
            r_m_valid <= n_m_valid;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_chunk   = r_chunk;
        n_m_valid = r_m_valid && !i_m_ready;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.mode == MODE_ADVANCE) begin
                    o_cmd.pop = 1'b1;
                    n_state   = ST_CNT_LD;
                end else begin
                    o_cmd.insert = 1'b1;
                    n_state      = ST_DONE;
                end
            end
            ST_CNT_LD: begin
                o_cmd.cnt_load = 1'b1;
                n_chunk        = KW'(NCH - 1);
                n_state        = ST_CNT;
            end
            ST_CNT: begin
                o_cmd.cnt_step = 1'b1;
                if (r_chunk == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_chunk = r_chunk - KW'(1);
                end
            end
            ST_DONE: begin
                // output register free or being emptied this cycle
                if (!r_m_valid || i_m_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_m_valid      = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_valid = r_m_valid;

endmodule
